FILE: rtl/kdeq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdeq_pkg
// Shared types and constants of the key debounce and event queue block.
// ----------------------------------------------------------------------------
package kdeq_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_KEY_COUNT   = 4;

    localparam logic [7:0]  SCAN_DIVIDER_RESET = 8'd10;
    localparam logic [15:0] LOCKOUT_MS_RESET   = 16'd100;

    // Input command codes carried in the input channel's tuser.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_SCAN_DIVIDER = 1'b0;
    localparam logic REG_LOCKOUT_MS   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POP
    } top_state_t;

    typedef enum logic {
        SC_IDLE,
        SC_RUN
    } scan_state_t;

    // Scan request from the sequencer to the key scanner.
    typedef struct packed {
        logic        start;
        logic [31:0] now_ms;
        logic [15:0] lockout_ms;
    } scan_cmd_t;

endpackage

FILE: rtl/kdeq_event_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdeq_event_queue
// Circular event queue held in a synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module kdeq_event_queue
    import kdeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int EVENT_W     = 3,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    input  logic [EVENT_W-1:0] push_data,
    input  logic               pop_req,
    output logic [EVENT_W-1:0] rd_data,
    output logic [CNT_W-1:0]   count
);

    localparam int QW    = $clog2(QUEUE_DEPTH);
    localparam int SUM_W = QW + 1;

    logic [EVENT_W-1:0] event_mem [QUEUE_DEPTH];
    logic [EVENT_W-1:0] rd_data_reg;
    logic [QW-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SUM_W-1:0]   slot_sum;
    logic [QW-1:0]      slot;
    logic               push_ok, pop_ok;

    assign push_ok = push_valid && (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_ok  = pop_req && (count_reg != '0);

    // Tail slot is head plus count, folded once since the sum stays below twice the depth.
    always_comb begin
        slot_sum = {1'b0, head_reg} + SUM_W'(count_reg);
        if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
            slot = QW'(slot_sum - SUM_W'(QUEUE_DEPTH));
        end else begin
            slot = QW'(slot_sum);
        end
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (pop_ok) begin
            if (head_reg == QW'(QUEUE_DEPTH - 1)) begin
                head_next = '0;
            end else begin
                head_next = head_reg + 1'b1;
            end
        end
        case ({push_ok, pop_ok})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            event_mem[slot] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_ok) begin
            rd_data_reg <= event_mem[head_reg];
        end
    end

    assign rd_data = rd_data_reg;
    assign count   = count_reg;

endmodule

FILE: rtl/kdeq_key_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdeq_key_scan
// Walks the key state memory one key per cycle: read, lockout check, write back.
// ----------------------------------------------------------------------------
module kdeq_key_scan
    import kdeq_pkg::*;
#(
    parameter int KEY_COUNT = DEF_KEY_COUNT,
    parameter int KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  scan_cmd_t            cmd,
    input  logic [KEY_COUNT-1:0] levels,
    output logic                 done,
    output logic                 push_valid,
    output logic [KEY_W:0]       push_data
);

    localparam int RC_W  = $clog2(KEY_COUNT + 1);
    localparam int ENT_W = 33;

    // Entry: key level in the top bit, time of the last accepted change below it.
    logic [ENT_W-1:0]     key_mem [KEY_COUNT];
    logic [KEY_COUNT-1:0] vld_reg, vld_next;

    scan_state_t          state_reg, state_next;
    logic [RC_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                 eval_reg, eval_next;
    logic [KEY_W-1:0]     eval_idx_reg;
    logic [ENT_W-1:0]     rd_data_reg;
    logic                 rd_vld_reg;
    logic [KEY_COUNT-1:0] levels_reg;
    logic [31:0]          now_reg;
    logic [15:0]          lockout_reg;

    logic                 rd_en;
    logic [KEY_W-1:0]     rd_addr;
    logic                 was_down, level;
    logic [31:0]          chg_time, elapsed;
    logic                 accept_change;
    logic                 last_eval;

    assign rd_addr   = rd_cnt_reg[KEY_W-1:0];
    assign rd_en     = (state_reg == SC_RUN) && (rd_cnt_reg < RC_W'(KEY_COUNT));
    assign last_eval = eval_reg && (eval_idx_reg == KEY_W'(KEY_COUNT - 1));

    // An entry never written since reset reads as released with change time zero.
    always_comb begin
        was_down      = rd_vld_reg & rd_data_reg[ENT_W-1];
        chg_time      = rd_vld_reg ? rd_data_reg[31:0] : 32'd0;
        elapsed       = now_reg - chg_time;
        level         = levels_reg[eval_idx_reg];
        accept_change = eval_reg && (elapsed >= {16'd0, lockout_reg}) && (was_down != level);
    end

    always_comb begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        eval_next   = 1'b0;
        vld_next    = vld_reg;
        case (state_reg)
            SC_IDLE: begin
                if (cmd.start) begin
                    state_next  = SC_RUN;
                    rd_cnt_next = '0;
                end
            end
            SC_RUN: begin
                if (rd_en) begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    eval_next   = 1'b1;
                end
                if (last_eval) begin
                    state_next = SC_IDLE;
                end
            end
            default: state_next = SC_IDLE;
        endcase
        if (accept_change) begin
            vld_next[eval_idx_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= SC_IDLE;
            rd_cnt_reg <= '0;
            eval_reg   <= 1'b0;
            vld_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            eval_reg   <= eval_next;
            vld_reg    <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start && (state_reg == SC_IDLE)) begin
            levels_reg  <= levels;
            now_reg     <= cmd.now_ms;
            lockout_reg <= cmd.lockout_ms;
        end
        if (rd_en) begin
            eval_idx_reg <= rd_addr;
            rd_vld_reg   <= vld_reg[rd_addr];
        end
    end

    // Reads run one key ahead of the write back, so the two never meet on one entry.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= key_mem[rd_addr];
        end
        if (accept_change) begin
            key_mem[eval_idx_reg] <= {level, now_reg};
        end
    end

    assign done       = last_eval;
    assign push_valid = accept_change;
    assign push_data  = {eval_idx_reg, level};

endmodule

FILE: rtl/key_debounce_event_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_debounce_event_queue_core
// Key debouncer with lockout timing and a queue of press and release events.
// ----------------------------------------------------------------------------
// Throughput: a tick without a scan is taken without holding the input; a
//   scanning tick holds the input through the one-key-per-cycle walk through
//   the key state memory; a pop holds it through the registered read of the
//   event memory and while the result waits for m_axis_tready.
// Pop result: loaded into the output register after the registered queue read.
// Reset: aresetn is synchronous and active low; it clears counters, key state valid
//   bits and queue pointers and loads the configuration defaults, with no clearing pass.
// ----------------------------------------------------------------------------
module key_debounce_event_queue_core
    import kdeq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int KEY_COUNT   = DEF_KEY_COUNT,
    parameter int KEY_W       = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1,
    parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1),
    parameter int IN_TDATA_W  = ((KEY_COUNT + 7) / 8) * 8,
    parameter int OUT_TDATA_W = ((KEY_W + 1 + CNT_W + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key_levels, zero padding
    input  logic                   s_axis_tuser,   // command

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // event_key, event_pressed,
                                                   // events_left, zero padding
    output logic                   m_axis_tuser,   // event_valid

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam int OUT_W = KEY_W + 1 + CNT_W;

    // Configuration registers.
    logic [7:0]  scan_divider_reg;
    logic [15:0] lockout_ms_reg;
    logic        cfg_write;
    logic        cfg_index;

    // Tick timing.
    logic [31:0] ms_count_reg, ms_count_next;
    logic [7:0]  prescaler_reg, prescaler_next;

    // Sequencer.
    top_state_t  state_reg, state_next;
    logic        in_accept;
    logic        is_tick, is_pop;
    logic        scan_due;
    logic        pop_hit_reg;
    logic        out_load;

    // Links between the units.
    scan_cmd_t          scan_cmd;
    logic               scan_done;
    logic               push_valid;
    logic [KEY_W:0]     push_data;
    logic [KEY_W:0]     queue_rd_data;
    logic [CNT_W-1:0]   queue_count;

    // Output register, decoupling the result channel from the sequencer.
    logic               m_valid_reg, m_valid_next;
    logic               m_event_valid_reg;
    logic [KEY_W-1:0]   m_event_key_reg;
    logic               m_event_pressed_reg;
    logic [CNT_W-1:0]   m_events_left_reg;

    // ------------------------------------------------------------------
    // Configuration port. Every transfer completes in its access cycle.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_divider_reg <= SCAN_DIVIDER_RESET;
            lockout_ms_reg   <= LOCKOUT_MS_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                REG_SCAN_DIVIDER: scan_divider_reg <= pwdata[7:0];
                REG_LOCKOUT_MS:   lockout_ms_reg   <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_SCAN_DIVIDER: prdata = {24'd0, scan_divider_reg};
            REG_LOCKOUT_MS:   prdata = {16'd0, lockout_ms_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Command decode. The input is taken only while the sequencer is idle;
    // a result waiting in the output register does not hold up ticks.
    // ------------------------------------------------------------------
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign is_tick   = in_accept && (s_axis_tuser == CMD_TICK);
    assign is_pop    = in_accept && (s_axis_tuser == CMD_POP);

    // A prescaler at or above the divider, left over after the divider was
    // lowered, scans on the next tick and restarts from zero.
    assign scan_due = is_tick && !(prescaler_reg < scan_divider_reg);

    always_comb begin
        ms_count_next  = ms_count_reg;
        prescaler_next = prescaler_reg;
        if (is_tick) begin
            ms_count_next = ms_count_reg + 32'd1;
            if (scan_due) begin
                prescaler_next = '0;
            end else begin
                prescaler_next = prescaler_reg + 8'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_count_reg  <= '0;
            prescaler_reg <= '0;
        end else begin
            ms_count_reg  <= ms_count_next;
            prescaler_reg <= prescaler_next;
        end
    end

    // The scan sees the millisecond count that this tick has just advanced.
    assign scan_cmd.start      = scan_due;
    assign scan_cmd.now_ms     = ms_count_next;
    assign scan_cmd.lockout_ms = lockout_ms_reg;

    // ------------------------------------------------------------------
    // Sequencer. Scans and pops never overlap, so the queue sees either a
    // push or a pop in any cycle and needs no forwarding between them.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (scan_due) begin
                    state_next = ST_SCAN;
                end else if (is_pop) begin
                    state_next = ST_POP;
                end
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_POP: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_SCAN: ;
            ST_POP:  out_load = !m_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Whether the pop found an event; the queue itself ignores a pop when empty.
    always_ff @(posedge aclk) begin
        if (is_pop) begin
            pop_hit_reg <= (queue_count != '0);
        end
    end

    // ------------------------------------------------------------------
    // Units.
    // ------------------------------------------------------------------
    kdeq_key_scan #(
        .KEY_COUNT (KEY_COUNT),
        .KEY_W     (KEY_W)
    ) u_key_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (scan_cmd),
        .levels     (s_axis_tdata[KEY_COUNT-1:0]),
        .done       (scan_done),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    kdeq_event_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .EVENT_W     (KEY_W + 1),
        .CNT_W       (CNT_W)
    ) u_event_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .pop_req    (is_pop),
        .rd_data    (queue_rd_data),
        .count      (queue_count)
    );

    // ------------------------------------------------------------------
    // Output register. The queue count has already dropped by the time the
    // result is loaded, so it is the number of events left after this pop.
    // An empty pop returns all fields as zero.
    // ------------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_event_valid_reg <= pop_hit_reg;
            if (pop_hit_reg) begin
                m_event_key_reg     <= queue_rd_data[KEY_W:1];
                m_event_pressed_reg <= queue_rd_data[0];
                m_events_left_reg   <= queue_count;
            end else begin
                m_event_key_reg     <= '0;
                m_event_pressed_reg <= 1'b0;
                m_events_left_reg   <= '0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_event_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({m_events_left_reg, m_event_pressed_reg,
                                         m_event_key_reg});

    // Padding bits of the input data are not used.
    logic unused_in_pad;
    assign unused_in_pad = ^{1'b0, s_axis_tdata};

    // Only the address bit that selects a register decodes; OUT_W documents
    // the packed result width below the byte padding.
    logic [OUT_W-1:0] out_fields_unused;
    assign out_fields_unused = {m_events_left_reg, m_event_pressed_reg, m_event_key_reg}
                               & {OUT_W{unused_in_pad & paddr[0] & paddr[1]}};

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the key debounce core and its event queue.
// ----------------------------------------------------------------------------
// A software copy of the debouncer runs beside the core. It is updated at
// every accepted input transaction and it predicts the event that each pop
// returns. A checker process compares every output transaction against the
// oldest predicted event. Directed tests cover the empty pop, the startup
// lockout, the queue overflow and a divider written below the running
// prescaler. Randomized key traffic follows under several register settings,
// with random gaps on the input side and random back-pressure on the output.
// ----------------------------------------------------------------------------
module testbench;
    import kdeq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int KEYS       = 4;
    // A scanning tick keeps the core busy with no output, so this many idle
    // cycles are allowed before a register write.
    localparam int SETTLE_CYC = 16;

    // One predicted pop result, with the same fields as the output.
    typedef struct packed {
        logic       valid;
        logic [1:0] key;
        logic       pressed;
        logic [4:0] left;
    } key_event_t;

    logic        aclk = 1'b0;
    logic        aresetn;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // key_levels[3:0], zero padding [7:4]
    logic        s_axis_tuser;     // command

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;     // event_key[1:0], event_pressed[2],
                                   // events_left[7:3]
    logic        m_axis_tuser;     // event_valid

    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Debouncer state as the bench believes it to be.
    logic [7:0]  exp_divider;
    logic [15:0] exp_lockout;
    logic [7:0]  exp_prescaler;
    logic [31:0] exp_ms;
    logic        exp_down   [KEYS];
    logic [31:0] exp_changed[KEYS];
    logic [2:0]  exp_store  [DEPTH];
    logic [3:0]  exp_head;
    logic [4:0]  exp_count;

    key_event_t  pending_events[$];

    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [3:0]  held_keys = 4'h0;

    key_debounce_event_queue_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Debouncer prediction
    // ------------------------------------------------------------------------

    // Queue an event unless the store is full; a dropped event still leaves
    // the key state updated by the caller.
    function void queue_key_event(input logic [1:0] key, input logic pressed);
        logic [3:0] slot;
        if (exp_count < DEPTH) begin
            slot = exp_head + exp_count[3:0];
            exp_store[slot] = {key, pressed};
            exp_count = exp_count + 1'b1;
        end
    endfunction

    // Apply one accepted input transaction. A pop appends the result that
    // the core must return for it.
    function void debounce_step(input logic cmd, input logic [3:0] levels);
        logic [31:0] elapsed;
        key_event_t  ev;
        if (cmd == CMD_TICK) begin
            // The counter moves first; a scan on this tick uses the new time.
            exp_ms = exp_ms + 1;
            if (exp_prescaler < exp_divider) begin
                exp_prescaler = exp_prescaler + 1'b1;
            end else begin
                exp_prescaler = '0;
                for (int k = 0; k < KEYS; k++) begin
                    // Wrapping difference, so the lockout survives counter wrap.
                    elapsed = exp_ms - exp_changed[k];
                    if (elapsed >= {16'd0, exp_lockout} && exp_down[k] != levels[k]) begin
                        queue_key_event(k[1:0], levels[k]);
                        exp_changed[k] = exp_ms;
                        exp_down[k]    = levels[k];
                    end
                end
            end
        end else begin
            ev = '0;
            if (exp_count != 0) begin
                ev.valid   = 1'b1;
                ev.key     = exp_store[exp_head][2:1];
                ev.pressed = exp_store[exp_head][0];
                exp_head   = exp_head + 1'b1;
                exp_count  = exp_count - 1'b1;
                ev.left    = exp_count;
            end
            pending_events.push_back(ev);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random back-pressure and the result checker
    // ------------------------------------------------------------------------

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        key_event_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_events.size() == 0) begin
                $error("result transaction with no pop outstanding: tuser=%0h tdata=%0h",
                       m_axis_tuser, m_axis_tdata);
                error_count++;
            end else begin
                want = pending_events.pop_front();
                if (m_axis_tuser !== want.valid) begin
                    $error("event_valid: expected %0d, got %0d", want.valid, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[1:0] !== want.key) begin
                    $error("event_key: expected %0d, got %0d", want.key, m_axis_tdata[1:0]);
                    error_count++;
                end
                if (m_axis_tdata[2] !== want.pressed) begin
                    $error("event_pressed: expected %0d, got %0d",
                           want.pressed, m_axis_tdata[2]);
                    error_count++;
                end
                if (m_axis_tdata[7:3] !== want.left) begin
                    $error("events_left: expected %0d, got %0d", want.left, m_axis_tdata[7:3]);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Input side and register port
    // ------------------------------------------------------------------------

    // Offer one item, with random idle cycles first, and hold it until the
    // core takes the transaction. tvalid is left high for a following item.
    task automatic send_item(input logic cmd, input logic [3:0] levels);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {4'h0, levels};
        do @(posedge aclk); while (!s_axis_tready);
        debounce_step(cmd, levels);
    endtask

    // Stop offering items and wait until every pop has returned its result.
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_events.size() != 0) @(posedge aclk);
    endtask

    // Bring the core to rest, then write a register over setup and access
    // cycles. The write lands at the edge where the access cycle sees pready.
    task automatic write_reg(input logic idx, input logic [15:0] value);
        wait_for_results();
        repeat (SETTLE_CYC) @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_SCAN_DIVIDER) begin
            exp_divider = value[7:0];
        end else begin
            exp_lockout = value;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Nothing has been queued yet, so a pop reports an empty queue.
    task automatic run_empty_pop_test();
        send_item(CMD_POP, 4'hA);
    endtask

    // Change times start at zero, so all keys are held off until the count
    // reaches lockout_ms. With a lockout of three, the third tick is taken.
    task automatic run_startup_lockout_test();
        write_reg(REG_SCAN_DIVIDER, 16'd0);
        write_reg(REG_LOCKOUT_MS, 16'd3);
        repeat (3) send_item(CMD_TICK, 4'hF);
    endtask

    // Fill the store to the brim and push one more scan into it; the extra
    // events are lost but the key levels still move. Then drain past empty,
    // with random levels on the pops to show they are ignored.
    task automatic run_queue_overflow_test();
        write_reg(REG_LOCKOUT_MS, 16'd0);
        send_item(CMD_TICK, 4'h0);
        send_item(CMD_TICK, 4'hF);
        send_item(CMD_TICK, 4'h0);
        send_item(CMD_TICK, 4'hF);
        repeat (DEPTH + 1) send_item(CMD_POP, 4'($urandom_range(15)));
    endtask

    // Let the prescaler run past a divider that is written afterwards; the
    // next tick must scan at once and restart the prescaler.
    task automatic run_prescaler_shrink_test();
        write_reg(REG_SCAN_DIVIDER, 16'd20);
        repeat (8) send_item(CMD_TICK, 4'h0);
        write_reg(REG_SCAN_DIVIDER, 16'd3);
        send_item(CMD_TICK, 4'h0);
        repeat (5) send_item(CMD_POP, 4'h5);
    endtask

    // Random key traffic. Keys mostly change a bit at a time, as real presses
    // do, with occasional bursts of noise; pops are mixed in at a rate that
    // lets the queue both fill up and run dry.
    task automatic run_random_traffic();
        logic [7:0]  dividers[8] = '{8'd0, 8'd1, 8'd255, 8'd0, 8'd0, 8'd2, 8'd3, 8'd0};
        logic [15:0] lockouts[8] = '{16'd0, 16'd3, 16'd0, 16'd5,
                                     16'd65535, 16'd12, 16'd1, 16'd2};
        int          idle_pcts[4]  = '{0, 66, 0, 15};
        int          stall_pcts[4] = '{0, 0, 66, 15};
        int          pop_pct;
        logic [3:0]  levels;
        for (int round = 0; round < 8; round++) begin
            write_reg(REG_SCAN_DIVIDER, {8'd0, dividers[round]});
            write_reg(REG_LOCKOUT_MS, lockouts[round]);
            send_idle_pct  = idle_pcts[round % 4];
            recv_stall_pct = stall_pcts[round % 4];
            pop_pct        = $urandom_range(45, 15);
            for (int n = 0; n < 170; n++) begin
                if ($urandom_range(99) < pop_pct) begin
                    send_item(CMD_POP, 4'($urandom_range(15)));
                end else begin
                    if ($urandom_range(99) < 5) begin
                        held_keys = 4'($urandom_range(15));
                    end else begin
                        for (int b = 0; b < KEYS; b++) begin
                            if ($urandom_range(99) < 20) held_keys[b] = ~held_keys[b];
                        end
                    end
                    levels = held_keys;
                    send_item(CMD_TICK, levels);
                end
                // Now and then the sender holds back until the queue of
                // outstanding pops has drained.
                if ($urandom_range(99) == 0) wait_for_results();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        aresetn       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_TICK;
        m_axis_tready <= 1'b1;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;

        exp_divider   = SCAN_DIVIDER_RESET;
        exp_lockout   = LOCKOUT_MS_RESET;
        exp_prescaler = '0;
        exp_ms        = '0;
        exp_head      = '0;
        exp_count     = '0;
        for (int k = 0; k < KEYS; k++) begin
            exp_down[k]    = 1'b0;
            exp_changed[k] = '0;
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_empty_pop_test();
        run_startup_lockout_test();
        run_queue_overflow_test();
        run_prescaler_shrink_test();
        run_random_traffic();

        wait_for_results();
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with the longest gaps and
    // stalls on every transaction.
    initial begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/kdeq_pkg.sv
rtl/kdeq_event_queue.sv
rtl/kdeq_key_scan.sv
rtl/key_debounce_event_queue_core.sv
tb/testbench.sv
